>>> rtl/core/gamma_ramp_generator_assert.svh
// ----------------------------------------------------------------------------
// Gamma ramp generator assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef GAMMA_RAMP_GENERATOR_ASSERT_SVH
`define GAMMA_RAMP_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define GRG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gamma ramp generator: assertion failed");
// checked at every edge, reset included
`define GRG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gamma ramp generator: assertion failed");
`else
`define GRG_ASSERT(lbl, clk, rst_n, prop)
`define GRG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/grg_pkg.sv
// ----------------------------------------------------------------------------
// Gamma ramp generator package
// Constants, types and helper functions shared by the ramp pipeline.
// ----------------------------------------------------------------------------
package grg_pkg;

  localparam int unsigned MaxRampEntries = 4096;

  // unsigned Q1.20
  localparam int unsigned FxBits = 20;
  localparam logic [20:0] FxOne  = 21'h10_0000;

  // long division: quotient bits resolved per pipeline stage
  localparam int unsigned DivStepBits = 3;
  localparam int unsigned Div1QBits   = 21;
  localparam int unsigned Div1Stages  = Div1QBits / DivStepBits;
  localparam int unsigned Div2QBits   = 27;
  localparam int unsigned Div2Stages  = Div2QBits / DivStepBits;

  localparam int unsigned LogSteps = 20;
  localparam int unsigned ExpBits  = 20;

  // floor(v/100) = (v * Recip100) >> 37 for v < 2^30
  localparam logic [30:0] Recip100      = 31'd1374389535;
  localparam int unsigned Recip100Shift = 37;
  // floor(v/10000) = (v * Recip10k) >> 44 for v < 2^30
  localparam logic [30:0] Recip10k      = 31'd1759218605;
  localparam int unsigned Recip10kShift = 44;

  localparam logic signed [31:0] ContrastBias = 32'sd52428800;   // 0.5 * 2^20 * 100
  localparam logic [38:0]        SatProduct   = 39'd10485760000; // 10000 * 2^20
  localparam logic [54:0]        LevelBias    = 55'd5242880000;  // 10000 * 2^19

  typedef enum logic [2:0] {
    CfgRampSize = 3'd0,
    CfgRed      = 3'd1,
    CfgGreen    = 3'd2,
    CfgBlue     = 3'd3,
    CfgWarmth   = 3'd4,
    CfgContrast = 3'd5,
    CfgGamma    = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic valid;
    logic zero;
  } pipe_tag_t;

  typedef struct packed {
    logic        q;
    logic [12:0] r;
  } div_step_t;

  // one restoring division step; rem must be below d
  function automatic div_step_t grg_div_step(input logic [12:0] rem, input logic din,
                                             input logic [12:0] d);
    logic [13:0] r2;
    div_step_t   s;
    r2 = {rem, din};
    if (r2 >= {1'b0, d}) begin
      s.q = 1'b1;
      r2  = r2 - {1'b0, d};
    end else begin
      s.q = 1'b0;
    end
    s.r = r2[12:0];
    return s;
  endfunction

  // floor square root, used for elaboration-time constants only
  function automatic logic [63:0] grg_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30
  function automatic logic [30:0] grg_exp_root(input int unsigned k);
    logic [63:0] r;
    r = grg_isqrt(64'd1 << 59);
    for (int unsigned j = 1; j < ExpBits; j++) begin
      if (j < k) begin
        r = grg_isqrt(r << 30);
      end
    end
    return r[30:0];
  endfunction

endpackage

>>> rtl/core/grg_log2.sv
// ----------------------------------------------------------------------------
// Gamma ramp generator log2 pipeline
// Computes -log2(y) in Q20 by normalization and repeated squaring.
// ----------------------------------------------------------------------------
module grg_log2
  import grg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [20:0] y_i,
  output pipe_tag_t   tag_o,
  output logic [24:0] l_o
);

  logic [LogSteps+2:0] v_q;
  logic [20:0]         y1_q;
  logic [4:0]          lead1_q;
  logic [4:0]          lead_d;

  logic [20:0] m_q    [LogSteps+1];
  logic [20:0] m_d    [LogSteps+1];
  logic [19:0] frac_q [LogSteps+1];
  logic [19:0] frac_d [LogSteps+1];
  logic [4:0]  ip_q   [LogSteps+1];
  logic        z_q    [LogSteps+1];
  logic [24:0] l_q;
  logic        zero_q;

  // leading one position
  always_comb begin
    lead_d = '0;
    for (int i = 0; i <= 20; i++) begin
      if (y_i[i]) begin
        lead_d = 5'(i);
      end
    end
  end

  always_comb begin : sq_comb
    logic [41:0] sq;
    logic [21:0] hi;
    m_d[0]    = 21'(y1_q << (5'd20 - lead1_q));
    frac_d[0] = '0;
    for (int k = 1; k <= LogSteps; k++) begin
      sq = {21'b0, m_q[k-1]} * {21'b0, m_q[k-1]};
      hi = sq[41:20];
      if (hi[21]) begin
        m_d[k]    = hi[21:1];
        frac_d[k] = {frac_q[k-1][18:0], 1'b1};
      end else begin
        m_d[k]    = hi[20:0];
        frac_d[k] = {frac_q[k-1][18:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[LogSteps+1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      y1_q    <= y_i;
      lead1_q <= lead_d;
      m_q     <= m_d;
      frac_q  <= frac_d;
      ip_q[0] <= 5'd20 - lead1_q;
      z_q[0]  <= (y1_q == '0);
      for (int k = 1; k <= LogSteps; k++) begin
        ip_q[k] <= ip_q[k-1];
        z_q[k]  <= z_q[k-1];
      end
      l_q    <= {ip_q[LogSteps], 20'b0} - 25'(frac_q[LogSteps]);
      zero_q <= z_q[LogSteps];
    end
  end

  assign tag_o.valid = v_q[LogSteps+2];
  assign tag_o.zero  = zero_q;
  assign l_o         = l_q;

endmodule

>>> rtl/core/grg_exp2.sv
// ----------------------------------------------------------------------------
// Gamma ramp generator exp2 pipeline
// Computes 2^-t in Q20 as a product of per-bit roots, one per stage.
// ----------------------------------------------------------------------------
module grg_exp2
  import grg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  pipe_tag_t            tag_i,
  input  logic [Div2QBits-1:0] t_i,
  output logic                 valid_o,
  output logic [20:0]          p_o
);

  logic [ExpBits+1:0] v_q;
  logic [30:0]        acc_q [ExpBits+1];
  logic [30:0]        acc_d [ExpBits+1];
  logic [19:0]        f_q   [ExpBits+1];
  logic [4:0]         q_q   [ExpBits+1];
  logic               z_q   [ExpBits+1];
  logic [6:0]         t_int;
  logic [30:0]        rnd;
  logic [20:0]        p_d;
  logic [20:0]        p_q;

  assign t_int    = t_i[Div2QBits-1:FxBits];
  assign acc_d[0] = 31'h4000_0000;

  for (genvar k = 1; k <= ExpBits; k++) begin : g_mul
    localparam logic [30:0] Root = grg_exp_root(k);
    logic [61:0] prod;
    assign prod     = {31'b0, acc_q[k-1]} * {31'b0, Root} + 62'h2000_0000;
    assign acc_d[k] = f_q[k-1][ExpBits-k] ? prod[60:30] : acc_q[k-1];
  end

  // round and drop to Q20 by the integer part
  always_comb begin
    rnd = acc_q[ExpBits] + (31'd1 << (5'd9 + q_q[ExpBits]));
    p_d = z_q[ExpBits] ? '0 : 21'(rnd >> (5'd10 + q_q[ExpBits]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[ExpBits:0], tag_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q  <= acc_d;
      f_q[0] <= t_i[FxBits-1:0];
      q_q[0] <= t_int[4:0];
      z_q[0] <= tag_i.zero || (t_int > 7'd20);
      for (int k = 1; k <= ExpBits; k++) begin
        f_q[k] <= f_q[k-1];
        q_q[k] <= q_q[k-1];
        z_q[k] <= z_q[k-1];
      end
      p_q <= p_d;
    end
  end

  assign valid_o = v_q[ExpBits+1];
  assign p_o     = p_q;

endmodule

>>> rtl/core/gamma_ramp_generator.sv
// ----------------------------------------------------------------------------
// Gamma ramp generator
// Computes the red, green and blue 16-bit gamma levels of one ramp entry.
// ----------------------------------------------------------------------------
// Usage:
//   Write the seven settings through cfg_we_i / cfg_index_i / cfg_data_i
//   while no entry is in flight; each write is registered, gains once more.
//   Present one entry index per input beat (in_valid_i, low in_stall_o).
//   Each accepted beat yields exactly one output beat carrying the three
//   levels, in input order.
//   Throughput: one entry per cycle while the output does not stall, set
//   by a 70-stage pipeline in which every divider, squaring and product
//   step has a register stage of its own.
//   Stall: while the output register is full and out_stall_i is high the
//   whole pipeline holds and in_stall_o is raised; nothing is dropped.
//   Reset: all settings return to their defaults (256 entries, every
//   percent setting 100) and the pipeline empties.
// ----------------------------------------------------------------------------
module gamma_ramp_generator
  import grg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_level_o,
  output logic [15:0] green_level_o,
  output logic [15:0] blue_level_o
);

  localparam int unsigned D1N = Div1Stages;
  localparam int unsigned D2N = Div2Stages;

  // --------------------------------------------------------------------------
  // Settings
  // --------------------------------------------------------------------------
  logic [12:0] ramp_size_q;
  logic [9:0]  red_pct_q;
  logic [9:0]  green_pct_q;
  logic [9:0]  blue_pct_q;
  logic [9:0]  warmth_pct_q;
  logic [9:0]  contrast_pct_q;
  logic [9:0]  gamma_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_size_q    <= 13'd256;
      red_pct_q      <= 10'd100;
      green_pct_q    <= 10'd100;
      blue_pct_q     <= 10'd100;
      warmth_pct_q   <= 10'd100;
      contrast_pct_q <= 10'd100;
      gamma_pct_q    <= 10'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgRampSize: ramp_size_q    <= cfg_data_i;
        CfgRed:      red_pct_q      <= cfg_data_i[9:0];
        CfgGreen:    green_pct_q    <= cfg_data_i[9:0];
        CfgBlue:     blue_pct_q     <= cfg_data_i[9:0];
        CfgWarmth:   warmth_pct_q   <= cfg_data_i[9:0];
        CfgContrast: contrast_pct_q <= cfg_data_i[9:0];
        CfgGamma:    gamma_pct_q    <= cfg_data_i[9:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Effective ramp size: zero counts as one, clip to the supported maximum.
  logic [12:0] n_ent;
  logic [12:0] nm1;
  logic        ramp_one;
  logic [9:0]  gp;

  always_comb begin
    if (ramp_size_q == '0) begin
      n_ent = 13'd1;
    end else if (17'(ramp_size_q) > 17'(MaxRampEntries)) begin
      n_ent = 13'(MaxRampEntries);
    end else begin
      n_ent = ramp_size_q;
    end
    nm1      = n_ent - 13'd1;
    ramp_one = (nm1 == '0);
    // floor gamma at one percent
    gp = (gamma_pct_q == '0) ? 10'd1 : gamma_pct_q;
  end

  // Channel gains in units of 1/10000; warmth pushes red and green.
  logic signed [19:0] warm_ofs;
  logic signed [19:0] gain_d [3];
  logic signed [19:0] gain_q [3];

  always_comb begin
    warm_ofs  = $signed({10'b0, warmth_pct_q}) - 20'sd100;
    gain_d[0] = $signed({10'b0, red_pct_q}) * 20'sd100 + warm_ofs * 20'sd70;
    gain_d[1] = $signed({10'b0, green_pct_q}) * 20'sd100 + warm_ofs * 20'sd45;
    gain_d[2] = $signed({10'b0, blue_pct_q}) * 20'sd100;
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together unless the output is stuck
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Entry position x = round(idx * 2^20 / (n-1)), long division, 3 bits/stage
  // --------------------------------------------------------------------------
  logic [D1N:0]          d1_v_q;
  logic [D1N:0]          d1_one_q;
  logic [12:0]           d1_rem_q [D1N+1];
  logic [12:0]           d1_rem_d [D1N+1];
  logic [Div1QBits-1:0]  d1_wrk_q [D1N+1];
  logic [Div1QBits-1:0]  d1_wrk_d [D1N+1];
  logic [11:0]           idx_sat;
  logic [32:0]           dvd1;

  always_comb begin : div1_comb
    logic [12:0]          r;
    logic [Div1QBits-1:0] w;
    div_step_t            st;
    // saturate the index to the last entry
    idx_sat     = (13'(entry_index_i) > nm1) ? nm1[11:0] : entry_index_i;
    dvd1        = (33'(idx_sat) << FxBits) + 33'(nm1 >> 1);
    d1_rem_d[0] = 13'(dvd1[32:Div1QBits]);
    d1_wrk_d[0] = dvd1[Div1QBits-1:0];
    for (int s = 1; s <= D1N; s++) begin
      r = d1_rem_q[s-1];
      w = d1_wrk_q[s-1];
      for (int b = 0; b < DivStepBits; b++) begin
        st = grg_div_step(r, w[Div1QBits-1], nm1);
        w  = {w[Div1QBits-2:0], st.q};
        r  = st.r;
      end
      d1_rem_d[s] = r;
      d1_wrk_d[s] = w;
    end
  end

  // --------------------------------------------------------------------------
  // Contrast about one half, then /100 by reciprocal and clamp to 0..1
  // --------------------------------------------------------------------------
  logic [20:0]        x_pos;
  logic signed [31:0] dx;
  logic signed [31:0] num;
  logic [29:0]        c1_val_d;
  logic [29:0]        c1_val_q;
  logic               c1_zero_d;
  logic               c1_zero_q;
  logic               c1_v_q;
  logic [60:0]        c2_prod_q;
  logic               c2_zero_q;
  logic               c2_v_q;
  logic [20:0]        y_clamp;

  always_comb begin
    // a one-entry ramp sits at full scale
    x_pos     = d1_one_q[D1N] ? FxOne : d1_wrk_q[D1N];
    dx        = $signed({11'b0, x_pos}) - 32'sd524288;
    num       = dx * $signed({22'b0, contrast_pct_q}) + ContrastBias;
    c1_zero_d = (num <= 32'sd0);
    c1_val_d  = 30'(num + 32'sd50);
  end

  always_comb begin
    if (c2_zero_q) begin
      y_clamp = '0;
    end else if (c2_prod_q[60:Recip100Shift] > 24'(FxOne)) begin
      y_clamp = FxOne;
    end else begin
      y_clamp = c2_prod_q[Recip100Shift+20:Recip100Shift];
    end
  end

  // --------------------------------------------------------------------------
  // -log2(y)
  // --------------------------------------------------------------------------
  pipe_tag_t   lg_tag;
  logic [24:0] lg_l;

  grg_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (c2_v_q),
    .y_i     (y_clamp),
    .tag_o   (lg_tag),
    .l_o     (lg_l)
  );

  // --------------------------------------------------------------------------
  // t = round(L * 100 / gamma), long division, 3 bits/stage
  // A quotient too wide for the divider is far past 2^-21 and reads as zero.
  // --------------------------------------------------------------------------
  logic [30:0]          t0_q;
  logic                 t0_zero_q;
  logic                 t0_v_q;
  logic [D2N:0]         d2_v_q;
  logic [D2N:0]         d2_zero_q;
  logic                 d2_ovf;
  logic [12:0]          d2_rem_q [D2N+1];
  logic [12:0]          d2_rem_d [D2N+1];
  logic [Div2QBits-1:0] d2_wrk_q [D2N+1];
  logic [Div2QBits-1:0] d2_wrk_d [D2N+1];

  always_comb begin : div2_comb
    logic [12:0]          r;
    logic [Div2QBits-1:0] w;
    div_step_t            st;
    d2_ovf      = 13'(t0_q[30:Div2QBits]) >= 13'(gp);
    d2_rem_d[0] = 13'(t0_q[30:Div2QBits]);
    d2_wrk_d[0] = t0_q[Div2QBits-1:0];
    for (int s = 1; s <= D2N; s++) begin
      r = d2_rem_q[s-1];
      w = d2_wrk_q[s-1];
      for (int b = 0; b < DivStepBits; b++) begin
        st = grg_div_step(r, w[Div2QBits-1], 13'(gp));
        w  = {w[Div2QBits-2:0], st.q};
        r  = st.r;
      end
      d2_rem_d[s] = r;
      d2_wrk_d[s] = w;
    end
  end

  // --------------------------------------------------------------------------
  // p = 2^-t
  // --------------------------------------------------------------------------
  pipe_tag_t   ex_tag;
  logic        ex_valid;
  logic [20:0] ex_p;

  assign ex_tag.valid = d2_v_q[D2N];
  assign ex_tag.zero  = d2_zero_q[D2N];

  grg_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tag_i   (ex_tag),
    .t_i     (d2_wrk_q[D2N]),
    .valid_o (ex_valid),
    .p_o     (ex_p)
  );

  // --------------------------------------------------------------------------
  // Gain, clamp and scale to 0..65535 with rounding
  // level = floor(floor((p*gain*65535 + 10000*2^19) / 2^20) / 10000)
  // --------------------------------------------------------------------------
  logic [2:0]  lv_v_q;
  logic [38:0] lv1_prod_d [3];
  logic [38:0] lv1_prod_q [3];
  logic        lv1_zero_d [3];
  logic        lv1_zero_q [3];
  logic [29:0] lv2_val_d  [3];
  logic [29:0] lv2_val_q  [3];
  logic        lv2_sat_q  [3];
  logic        lv2_zero_q [3];
  logic [54:0] lv2_acc    [3];
  logic [60:0] lv3_prod_q [3];
  logic        lv3_sat_q  [3];
  logic        lv3_zero_q [3];
  logic [15:0] level_d    [3];
  logic [15:0] level_q    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lv1_prod_d[c] = 39'(ex_p) * 39'(gain_q[c][17:0]);
      // a gain at or below zero blanks the channel
      lv1_zero_d[c] = (gain_q[c] <= 20'sd0) || (ex_p == '0);
      lv2_acc[c]    = ({lv1_prod_q[c], 16'b0} - 55'(lv1_prod_q[c])) + LevelBias;
      lv2_val_d[c]  = lv2_acc[c][49:20];
      if (lv3_zero_q[c]) begin
        level_d[c] = '0;
      end else if (lv3_sat_q[c]) begin
        level_d[c] = 16'hFFFF;
      end else begin
        level_d[c] = lv3_prod_q[c][Recip10kShift+15:Recip10kShift];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q      <= '0;
      c1_v_q      <= 1'b0;
      c2_v_q      <= 1'b0;
      t0_v_q      <= 1'b0;
      d2_v_q      <= '0;
      lv_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      d1_v_q      <= {d1_v_q[D1N-1:0], in_valid_i};
      c1_v_q      <= d1_v_q[D1N];
      c2_v_q      <= c1_v_q;
      t0_v_q      <= lg_tag.valid;
      d2_v_q      <= {d2_v_q[D2N-1:0], t0_v_q};
      lv_v_q      <= {lv_v_q[1:0], ex_valid};
      out_valid_q <= lv_v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_rem_q  <= d1_rem_d;
      d1_wrk_q  <= d1_wrk_d;
      d1_one_q  <= {d1_one_q[D1N-1:0], ramp_one};
      c1_val_q  <= c1_val_d;
      c1_zero_q <= c1_zero_d;
      c2_prod_q <= {31'b0, c1_val_q} * {30'b0, Recip100};
      c2_zero_q <= c1_zero_q;
      t0_q      <= 31'(lg_l) * 31'd100 + 31'(gp >> 1);
      t0_zero_q <= lg_tag.zero;
      d2_rem_q  <= d2_rem_d;
      d2_wrk_q  <= d2_wrk_d;
      d2_zero_q <= {d2_zero_q[D2N-1:0], t0_zero_q || d2_ovf};
      for (int c = 0; c < 3; c++) begin
        lv1_prod_q[c] <= lv1_prod_d[c];
        lv1_zero_q[c] <= lv1_zero_d[c];
        lv2_val_q[c]  <= lv2_val_d[c];
        lv2_sat_q[c]  <= lv1_prod_q[c] >= SatProduct;
        lv2_zero_q[c] <= lv1_zero_q[c];
        lv3_prod_q[c] <= {31'b0, lv2_val_q[c]} * {30'b0, Recip10k};
        lv3_sat_q[c]  <= lv2_sat_q[c];
        lv3_zero_q[c] <= lv2_zero_q[c];
        level_q[c]    <= level_d[c];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = level_q[0];
  assign green_level_o = level_q[1];
  assign blue_level_o  = level_q[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "gamma_ramp_generator_assert.svh"

  // an empty output register never holds back the input
  `GRG_ASSERT_ALWAYS(a_empty_no_stall, clk_i, !out_valid_o |-> !in_stall_o)
  // a red gain at or below zero gives a black red channel
  `GRG_ASSERT(a_red_blank, clk_i, rst_ni, out_valid_o && (gain_q[0] <= 20'sd0) |-> red_level_o == '0)
  // equal red and blue gains give equal red and blue levels
  `GRG_ASSERT(a_equal_gain, clk_i, rst_ni, out_valid_o && (gain_q[0] == gain_q[2]) |-> red_level_o == blue_level_o)

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Gamma ramp generator testbench
// Drives ramp entry indexes through the pipeline under several register
// settings and random back pressure, and compares every output beat with
// the levels worked out by a fixed-point predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import grg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // index 7 is not decoded by the block; a write there must be ignored
  localparam logic [2:0] CfgUnused   = 3'd7;
  localparam int         CycleLimit  = 400000;
  localparam int         DrainCycles = 100;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } ramp_levels_t;

  // floor square root
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // -log2(y) in Q20 for 0 < y <= 1.0
  function automatic longint unsigned minus_log2(longint unsigned y);
    int              lead;
    longint unsigned m, frac;
    lead = 20;
    frac = 0;
    while (lead > 0 && y[lead] == 1'b0) lead--;
    m = y << (20 - lead);
    for (int k = 1; k <= 20; k++) begin
      m = (m * m) >> 20;
      if (m >= (64'd2 << 20)) begin
        m    = m >> 1;
        frac = frac | ((64'd1 << 20) >> k);
      end
    end
    return longint'(20 - lead) * (64'd1 << 20) - frac;
  endfunction

  // 2^-t, t and result in Q20
  function automatic longint unsigned pow2_neg(longint unsigned t);
    longint unsigned q, f, acc, r;
    q   = t >> 20;
    f   = t & 64'hF_FFFF;
    acc = 64'd1 << 30;
    r   = floor_sqrt(64'd1 << 59);
    if (q > 20) return 0;
    for (int k = 1; k <= 20; k++) begin
      if (f[20-k]) acc = (acc * r + (64'd1 << 29)) >> 30;
      r = floor_sqrt(r << 30);
    end
    return (acc + (64'd1 << (9 + q))) >> (10 + q);
  endfunction

  function automatic logic [15:0] scale_level(longint unsigned p, longint gain);
    longint unsigned prod;
    if (gain <= 0 || p == 0) return 16'd0;
    prod = p * longint'(gain);
    if (prod >= 64'd10000 * (64'd1 << 20)) return 16'hFFFF;
    return 16'((prod * 65535 + 64'd10000 * (64'd1 << 19)) / (64'd10000 * (64'd1 << 20)));
  endfunction

  class ramp_scoreboard;
    logic [12:0]  size_r;
    logic [9:0]   red_r, green_r, blue_r, warmth_r, contrast_r, gamma_r;
    ramp_levels_t pending[$];
    int           mismatches;
    int           checked;

    function new();
      size_r = 13'd256;
      {red_r, green_r, blue_r, warmth_r, contrast_r, gamma_r} = {6{10'd100}};
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_setting(logic [2:0] idx, logic [12:0] data);
      case (idx)
        CfgRampSize: size_r     = data;
        CfgRed:      red_r      = data[9:0];
        CfgGreen:    green_r    = data[9:0];
        CfgBlue:     blue_r     = data[9:0];
        CfgWarmth:   warmth_r   = data[9:0];
        CfgContrast: contrast_r = data[9:0];
        CfgGamma:    gamma_r    = data[9:0];
        default: ;
      endcase
    endfunction

    function ramp_levels_t levels_for(logic [11:0] entry);
      longint unsigned n, idx, x, y, p, gp;
      longint          num, w, g_red, g_green, g_blue;
      ramp_levels_t    lv;
      n = size_r;
      if (n == 0) n = 1;
      if (n > MaxRampEntries) n = MaxRampEntries;
      idx = entry;
      if (idx > n - 1) idx = n - 1;
      if (n == 1) x = 64'd1 << 20;
      else x = (idx * (64'd1 << 20) + (n - 1) / 2) / (n - 1);
      num = 64'sd52428800 + (longint'(x) - 64'sd524288) * longint'(contrast_r);
      if (num <= 0) y = 0;
      else y = (longint'(num) + 50) / 100;
      if (y > (64'd1 << 20)) y = 64'd1 << 20;
      gp = (gamma_r < 1) ? 1 : gamma_r;
      if (y == 0) p = 0;
      else p = pow2_neg((minus_log2(y) * 100 + gp / 2) / gp);
      w       = longint'(warmth_r) - 100;
      g_red   = longint'(red_r) * 100 + w * 70;
      g_green = longint'(green_r) * 100 + w * 45;
      g_blue  = longint'(blue_r) * 100;
      lv.red   = scale_level(p, g_red);
      lv.green = scale_level(p, g_green);
      lv.blue  = scale_level(p, g_blue);
      return lv;
    endfunction

    function void note_entry(logic [11:0] entry);
      pending.push_back(levels_for(entry));
    endfunction

    function void check_levels(ramp_levels_t got);
      ramp_levels_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("level mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = CfgRampSize;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [11:0] entry_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] red_level_o, green_level_o, blue_level_o;

  ramp_scoreboard levels_sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;
  int sent           = 0;
  int settings_used  = 0;

  // directed entry lists
  int default_entries [8] = '{0, 1, 127, 128, 255, 256, 2048, 4095};
  int wide_entries    [5] = '{0, 1, 2047, 4094, 4095};
  int pair_entries    [3] = '{0, 1, 4095};
  int full_entries    [5] = '{0, 1, 2048, 4095, 4095};

  gamma_ramp_generator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .entry_index_i,
    .out_valid_o, .out_stall_i, .red_level_o, .green_level_o, .blue_level_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Count cycles and bail out if the pipeline hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d beats still expected", levels_sb.pending.size());
      $display("gamma_ramp_generator verification failed");
      $finish;
    end
  end

  // Receiver back pressure: redraw the stall at every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Collect each output beat that the receiver takes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      levels_sb.check_levels({red_level_o, green_level_o, blue_level_o});
  end

  // Send one entry index; hold it until the block takes the beat.
  task automatic send_entry(logic [11:0] entry);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    entry_index_i = entry;
    do @(posedge clk_i); while (in_stall_o);
    levels_sb.note_entry(entry);
    sent++;
  endtask

  // Drop valid and wait until every expected beat is back.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (levels_sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    levels_sb.write_setting(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_settings(logic [12:0] size, logic [12:0] red, logic [12:0] green,
                               logic [12:0] blue, logic [12:0] warmth,
                               logic [12:0] contrast, logic [12:0] gam);
    drain_pipeline();
    write_reg(CfgRampSize, size);
    write_reg(CfgRed, red);
    write_reg(CfgGreen, green);
    write_reg(CfgBlue, blue);
    write_reg(CfgWarmth, warmth);
    write_reg(CfgContrast, contrast);
    write_reg(CfgGamma, gam);
    settings_used++;
  endtask

  function automatic logic [12:0] rand_percent();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd1000;
      2: return 13'd1023;
      3: return 13'($urandom_range(8191)); // upper bits are dropped by the block
      4: return 13'd100;
      default: return 13'($urandom_range(1000));
    endcase
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'($urandom_range(8191, 4097));
      4: return 13'($urandom_range(64, 2));
      default: return 13'($urandom_range(4096, 1));
    endcase
  endfunction

  initial begin
    logic [11:0] entry;
    int          n_size;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults straight out of reset: ramp ends, midpoint, index past the ramp.
    foreach (default_entries[i]) send_entry(12'(default_entries[i]));

    // Zero size, zero gamma floored, full contrast, negative green gain.
    load_settings(13'd0, 13'd1023, 13'd0, 13'd1023, 13'd0, 13'd1023, 13'd0);
    send_entry(12'd0);
    send_entry(12'd4095);
    // Oversized ramp, no contrast, maximum warmth, wide gamma.
    load_settings(13'd8191, 13'd0, 13'd1000, 13'd0, 13'd1023, 13'd0, 13'd1000);
    foreach (wide_entries[i]) send_entry(12'(wide_entries[i]));
    // Two-entry ramp, strong contrast clips both ends, tiny gamma, red negative.
    load_settings(13'd2, 13'd10, 13'd500, 13'd1000, 13'd0, 13'd1000, 13'd1);
    foreach (pair_entries[i]) send_entry(12'(pair_entries[i]));
    // Full ramp, a write to the undecoded index must change nothing.
    load_settings(13'd4096, 13'd100, 13'd100, 13'd100, 13'd100, 13'd100, 13'd250);
    write_reg(CfgUnused, 13'h1FFF);
    foreach (full_entries[i]) send_entry(12'(full_entries[i]));

    // Random part: three pressure profiles, each with two random settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 16; recv_stall_pct = 80; end
        1: begin send_idle_pct = 80; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      load_settings(rand_size(), rand_percent(), rand_percent(), rand_percent(),
                    rand_percent(), rand_percent(), rand_percent());
      n_size = (levels_sb.size_r == 0) ? 1 : levels_sb.size_r;
      for (int i = 0; i < 135; i++) begin
        if (ph == 1 && i == 60) drain_pipeline();
        // mostly entries inside the ramp, some anywhere in the index range
        if ($urandom_range(3) == 0) entry = 12'($urandom_range(4095));
        else entry = 12'($urandom_range((n_size > 4096 ? 4096 : n_size) - 1));
        send_entry(entry);
      end
    end

    drain_pipeline();
    repeat (DrainCycles) @(negedge clk_i);
    $display("sent %0d entries, checked %0d beats over %0d register settings",
             sent, levels_sb.checked, settings_used + 1);
    $display("mismatches: %0d", levels_sb.mismatches);
    if (levels_sb.mismatches == 0 && levels_sb.pending.size() == 0)
      $display("gamma_ramp_generator verification clean");
    else
      $display("gamma_ramp_generator verification failed");
    $finish;
  end

endmodule
